/* src/rszb_pkg.sv */
// Shared types and constants for the ray-sphere zone breach predictor.
`timescale 1ns / 1ps
package rszb_pkg;

  // Configuration space
  localparam int GEOM_REGS     = 4;
  localparam int MAX_ZONES_DEF = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEOM_BASE  = 3'd1;

  // Shared unit widths
  localparam int ACC_W = 72;   // accumulator / remainder
  localparam int REM_W = 38;   // square root partial remainder
  localparam int RES_W = 34;   // root or quotient
  localparam int OPD_W = 17;   // multiplier operand (one chunk)

  // Result codes and limits
  localparam logic [15:0] T_NONE       = 16'hFFFF;
  localparam logic [16:0] D_NONE       = 17'h1FFFF;
  localparam logic [15:0] HORIZON_MAX  = 16'd65534;
  localparam logic [31:0] MIN_SPEED_SQ = 32'd100;
  localparam logic [OPD_W-1:0] MS_PER_S = 17'd1000;

  // Product alignment for chunked products
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_17 = 2'd1;
  localparam logic [1:0] SH_34 = 2'd2;

  typedef enum logic [2:0] {
    AOP_NOP = 3'd0,
    AOP_MAC = 3'd1,   // acc = (clr ? 0 : acc) +/- (x*y << sh)
    AOP_SQI = 3'd2,   // load root operand, clear root and remainder
    AOP_SQS = 3'd3,   // one root digit
    AOP_DVI = 3'd4,   // load aligned divisor, clear quotient
    AOP_DVS = 3'd5    // one quotient bit, dividend in acc
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic             clr;
    logic             neg;
    logic [1:0]       sh;
    logic [OPD_W-1:0] x;
    logic [OPD_W-1:0] y;
    logic [ACC_W-1:0] wide;
  } alu_cmd_t;

endpackage

/* src/ray_sphere_zone_breach_predictor.sv */
// Top level of the ray-sphere zone breach predictor: sequencer, registers, ports.
`timescale 1ns / 1ps
// One query (current position, velocity, predicted position, horizon) is
// checked against each configured sphere zone in turn. For each zone the
// block finds the earliest boundary entry time within the horizon (0 when
// the point is already inside) by solving the ray-sphere quadratic in exact
// integer arithmetic, and also checks whether the predicted point lies
// strictly inside. Speeds under 10 mm/s give no usable entry time. The
// earliest breach wins, the lower zone index on a tie, and the result
// carries its time and floor(sqrt) distance from the predicted point to the
// zone centre; with no breach the result reads inactive, zone 0, time 65535
// and distance 131071. All arithmetic runs through one shared unit: a
// 17x17 multiply-accumulate that also performs one square-root digit or one
// quotient bit per cycle. A query first finds the speed, then works each
// zone in turn (the 34-step discriminant square root and up to two
// 17-step divides dominate), then takes the distance root of the winner, if any.
// The input is ready only while the sequencer is idle; the finished result
// sits in an output register, so the next query can transfer while it waits.
// Configuration is a plain write port (index 0 zone count, 1..4 geometry);
// write it only while no query is in flight.
module ray_sphere_zone_breach_predictor import rszb_pkg::*; #(
  parameter int MAX_ZONES = MAX_ZONES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // query channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_cur_x,
  input  logic signed [15:0]    in_cur_y,
  input  logic signed [15:0]    in_cur_z,
  input  logic signed [15:0]    in_vel_x,
  input  logic signed [15:0]    in_vel_y,
  input  logic signed [15:0]    in_vel_z,
  input  logic signed [15:0]    in_pred_x,
  input  logic signed [15:0]    in_pred_y,
  input  logic signed [15:0]    in_pred_z,
  input  logic [15:0]           in_horizon_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_breach_active,
  output logic [1:0]            out_zone_index,
  output logic [15:0]           out_impact_time_ms,
  output logic [16:0]           out_predicted_distance_mm,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ZLIM   = (MAX_ZONES < GEOM_REGS) ? MAX_ZONES : GEOM_REGS;
  localparam int K_W    = 6;
  localparam int SQ_D   = 34;             // digits of the discriminant root
  localparam int SQ_P   = 17;             // digits of the distance root
  localparam int DV_N   = 17;             // quotient bits incl. overflow bit
  localparam int D_SH   = ACC_W - 2*SQ_D; // align discriminant to the top
  localparam int P_SH   = ACC_W - 2*SQ_P;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SPEED = 11'b000_0000_0010,
    S_H     = 11'b000_0000_0100,
    S_C     = 11'b000_0000_1000,
    S_D2    = 11'b000_0001_0000,
    S_DISC  = 11'b000_0010_0000,
    S_SQRT  = 11'b000_0100_0000,
    S_NUM   = 11'b000_1000_0000,
    S_DIV   = 11'b001_0000_0000,
    S_ZEND  = 11'b010_0000_0000,
    S_DIST  = 11'b100_0000_0000
  } state_t;

  function automatic logic [15:0] sel3(input logic [1:0] i, input logic [15:0] a,
                                       input logic [15:0] b, input logic [15:0] c);
    logic [15:0] r;
    case (i)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] abs17(input logic [16:0] v);
    return v[16] ? (17'd0 - v) : v;
  endfunction

  // configuration registers
  logic [2:0]            zone_count_r;
  logic [CFG_DATA_W-1:0] geom_r [GEOM_REGS];

  // control
  state_t         state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic           j_r, j_nxt;
  logic [1:0]     zi_r, zi_nxt;
  logic           out_valid_r, out_valid_nxt;

  // query and per-zone working registers
  logic [15:0] cur_r [3];
  logic [15:0] vel_r [3];
  logic [15:0] prd_r [3];
  logic [15:0] hz_r;
  logic [31:0] a_r, a_nxt;
  logic        slow_r, slow_nxt;
  logic [33:0] h_r, h_nxt;
  logic [33:0] c_r, c_nxt;
  logic        cneg_r, cneg_nxt;
  logic [33:0] d2_r, d2_nxt;
  logic        inside_r, inside_nxt;
  logic [33:0] s_r, s_nxt;
  logic        tfound_r, tfound_nxt;
  logic [15:0] t_r, t_nxt;
  logic [15:0] best_t_r, best_t_nxt;
  logic [1:0]  best_z_r, best_z_nxt;
  logic [33:0] best_d2_r, best_d2_nxt;
  logic        active_r, active_nxt;

  logic        out_breach_active_r, out_breach_active_nxt;
  logic [1:0]  out_zone_index_r, out_zone_index_nxt;
  logic [15:0] out_impact_time_ms_r, out_impact_time_ms_nxt;
  logic [16:0] out_predicted_distance_mm_r, out_predicted_distance_mm_nxt;

  // shared unit
  alu_cmd_t         cmd;
  logic [ACC_W-1:0] acc;
  logic [RES_W-1:0] res;

  rszb_alu u_alu (
    .clk (clk),
    .cmd (cmd),
    .acc (acc),
    .res (res)
  );

  logic            accept;
  logic [2:0]      n_eff;
  logic            zi_last;
  logic [63:0]     g;
  logic [15:0]     zc_sel, cur_sel, vel_sel, prd_sel, rad;
  logic [16:0]     o_sel, d_sel, v_sel;
  logic [33:0]     hmag;
  logic [35:0]     h36, s36, num;
  logic [16:0]     q;
  logic            hit;
  logic [15:0]     tti;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign n_eff   = (zone_count_r > 3'(ZLIM)) ? 3'(ZLIM) : zone_count_r;
  assign zi_last = (({1'b0, zi_r} + 3'd1) == n_eff);

  // operand selection: component chosen by the low step bits
  always_comb begin
    g       = geom_r[zi_r];
    rad     = g[63:48];
    zc_sel  = sel3(k_r[1:0], g[15:0], g[31:16], g[47:32]);
    cur_sel = sel3(k_r[1:0], cur_r[0], cur_r[1], cur_r[2]);
    vel_sel = sel3(k_r[1:0], vel_r[0], vel_r[1], vel_r[2]);
    prd_sel = sel3(k_r[1:0], prd_r[0], prd_r[1], prd_r[2]);
    o_sel   = {cur_sel[15], cur_sel} - {zc_sel[15], zc_sel};
    d_sel   = {prd_sel[15], prd_sel} - {zc_sel[15], zc_sel};
    v_sel   = {vel_sel[15], vel_sel};
    hmag    = h_r[33] ? (34'd0 - h_r) : h_r;
    h36     = {{2{h_r[33]}}, h_r};
    s36     = {2'b00, s_r};
    num     = j_r ? (s36 - h36) : (36'd0 - h36 - s36);
    q       = res[16:0];
    hit     = tfound_r || inside_r;
    tti     = !tfound_r ? 16'd0 : (slow_r ? T_NONE : t_r);
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    zi_nxt      = zi_r;
    a_nxt       = a_r;
    slow_nxt    = slow_r;
    h_nxt       = h_r;
    c_nxt       = c_r;
    cneg_nxt    = cneg_r;
    d2_nxt      = d2_r;
    inside_nxt  = inside_r;
    s_nxt       = s_r;
    tfound_nxt  = tfound_r;
    t_nxt       = t_r;
    best_t_nxt  = best_t_r;
    best_z_nxt  = best_z_r;
    best_d2_nxt = best_d2_r;
    active_nxt  = active_r;
    out_valid_nxt                 = out_valid_r && !out_ready;
    out_breach_active_nxt         = out_breach_active_r;
    out_zone_index_nxt            = out_zone_index_r;
    out_impact_time_ms_nxt        = out_impact_time_ms_r;
    out_predicted_distance_mm_nxt = out_predicted_distance_mm_r;
    cmd    = '0;
    cmd.op = AOP_NOP;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          best_t_nxt = T_NONE;
          best_z_nxt = 2'd0;
          active_nxt = 1'b0;
          k_nxt      = '0;
          state_nxt  = S_SPEED;
        end
      end

      // a = |v|^2
      S_SPEED: begin
        if (k_r < K_W'(3)) begin
          cmd.op  = AOP_MAC;
          cmd.clr = (k_r == '0);
          cmd.x   = abs17(v_sel);
          cmd.y   = abs17(v_sel);
          k_nxt   = k_r + K_W'(1);
        end else begin
          a_nxt     = acc[31:0];
          slow_nxt  = acc[31:0] < MIN_SPEED_SQ;
          zi_nxt    = 2'd0;
          k_nxt     = '0;
          state_nxt = (n_eff == 3'd0) ? S_DIST : S_H;
        end
      end

      // h = o.v
      S_H: begin
        if (k_r < K_W'(3)) begin
          cmd.op  = AOP_MAC;
          cmd.clr = (k_r == '0);
          cmd.neg = o_sel[16] ^ v_sel[16];
          cmd.x   = abs17(o_sel);
          cmd.y   = abs17(v_sel);
          k_nxt   = k_r + K_W'(1);
        end else begin
          h_nxt     = acc[33:0];
          k_nxt     = '0;
          state_nxt = S_C;
        end
      end

      // c = |o|^2 - r^2
      S_C: begin
        if (k_r < K_W'(3)) begin
          cmd.op  = AOP_MAC;
          cmd.clr = (k_r == '0);
          cmd.x   = abs17(o_sel);
          cmd.y   = abs17(o_sel);
          k_nxt   = k_r + K_W'(1);
        end else if (k_r == K_W'(3)) begin
          cmd.op  = AOP_MAC;
          cmd.neg = 1'b1;
          cmd.x   = {1'b0, rad};
          cmd.y   = {1'b0, rad};
          k_nxt   = k_r + K_W'(1);
        end else begin
          cneg_nxt  = acc[ACC_W-1];
          c_nxt     = acc[33:0];
          k_nxt     = '0;
          state_nxt = S_D2;
        end
      end

      // d2 = |pred - centre|^2, then inside test against r^2
      S_D2: begin
        if (k_r < K_W'(3)) begin
          cmd.op  = AOP_MAC;
          cmd.clr = (k_r == '0);
          cmd.x   = abs17(d_sel);
          cmd.y   = abs17(d_sel);
          k_nxt   = k_r + K_W'(1);
        end else if (k_r == K_W'(3)) begin
          d2_nxt  = acc[33:0];
          cmd.op  = AOP_MAC;
          cmd.neg = 1'b1;
          cmd.x   = {1'b0, rad};
          cmd.y   = {1'b0, rad};
          k_nxt   = k_r + K_W'(1);
        end else begin
          inside_nxt = acc[ACC_W-1];
          k_nxt      = '0;
          if (cneg_r) begin
            // already inside the sphere: entry at time zero
            tfound_nxt = 1'b1;
            t_nxt      = 16'd0;
            state_nxt  = S_ZEND;
          end else if (a_r == 32'd0) begin
            tfound_nxt = 1'b0;
            state_nxt  = S_ZEND;
          end else begin
            state_nxt = S_DISC;
          end
        end
      end

      // D = h^2 - a*c from 17-bit chunks
      S_DISC: begin
        if (k_r < K_W'(8)) begin
          cmd.op = AOP_MAC;
          case (k_r[2:0])
            3'd0: begin
              cmd.clr = 1'b1; cmd.x = hmag[16:0];  cmd.y = hmag[16:0];  cmd.sh = SH_0;
            end
            3'd1: begin
              cmd.x = hmag[16:0];  cmd.y = hmag[33:17]; cmd.sh = SH_17;
            end
            3'd2: begin
              cmd.x = hmag[33:17]; cmd.y = hmag[16:0];  cmd.sh = SH_17;
            end
            3'd3: begin
              cmd.x = hmag[33:17]; cmd.y = hmag[33:17]; cmd.sh = SH_34;
            end
            3'd4: begin
              cmd.neg = 1'b1; cmd.x = a_r[16:0]; cmd.y = c_r[16:0]; cmd.sh = SH_0;
            end
            3'd5: begin
              cmd.neg = 1'b1; cmd.x = a_r[16:0]; cmd.y = c_r[33:17]; cmd.sh = SH_17;
            end
            3'd6: begin
              cmd.neg = 1'b1; cmd.x = {2'b00, a_r[31:17]}; cmd.y = c_r[16:0];
              cmd.sh  = SH_17;
            end
            default: begin
              cmd.neg = 1'b1; cmd.x = {2'b00, a_r[31:17]}; cmd.y = c_r[33:17];
              cmd.sh  = SH_34;
            end
          endcase
          k_nxt = k_r + K_W'(1);
        end else begin
          k_nxt = '0;
          if (acc[ACC_W-1]) begin
            tfound_nxt = 1'b0;
            state_nxt  = S_ZEND;
          end else begin
            cmd.op    = AOP_SQI;
            cmd.wide  = acc << D_SH;
            state_nxt = S_SQRT;
          end
        end
      end

      // s = floor(sqrt(D)), one digit per cycle
      S_SQRT: begin
        if (k_r < K_W'(SQ_D)) begin
          cmd.op = AOP_SQS;
          k_nxt  = k_r + K_W'(1);
        end else begin
          s_nxt     = res[33:0];
          j_nxt     = 1'b0;
          k_nxt     = '0;
          state_nxt = S_NUM;
        end
      end

      // N = 1000 * (-h -/+ s), skip a negative numerator
      S_NUM: begin
        if (k_r == '0) begin
          if (num[35]) begin
            if (!j_r) begin
              j_nxt = 1'b1;
            end else begin
              tfound_nxt = 1'b0;
              state_nxt  = S_ZEND;
            end
          end else begin
            cmd.op  = AOP_MAC;
            cmd.clr = 1'b1;
            cmd.x   = num[16:0];
            cmd.y   = MS_PER_S;
            cmd.sh  = SH_0;
            k_nxt   = k_r + K_W'(1);
          end
        end else if (k_r == K_W'(1)) begin
          cmd.op = AOP_MAC;
          cmd.x  = num[33:17];
          cmd.y  = MS_PER_S;
          cmd.sh = SH_17;
          k_nxt  = k_r + K_W'(1);
        end else if (k_r == K_W'(2)) begin
          cmd.op = AOP_MAC;
          cmd.x  = {16'd0, num[34]};
          cmd.y  = MS_PER_S;
          cmd.sh = SH_34;
          k_nxt  = k_r + K_W'(1);
        end else begin
          // divisor aligned so the top quotient bit flags an overflow
          cmd.op    = AOP_DVI;
          cmd.wide  = ACC_W'({a_r, 16'd0});
          k_nxt     = '0;
          state_nxt = S_DIV;
        end
      end

      // t = floor(N / a), accept if it fits the horizon
      S_DIV: begin
        if (k_r < K_W'(DV_N)) begin
          cmd.op = AOP_DVS;
          k_nxt  = k_r + K_W'(1);
        end else begin
          k_nxt = '0;
          if (!q[16] && (q[15:0] <= hz_r)) begin
            tfound_nxt = 1'b1;
            t_nxt      = q[15:0];
            state_nxt  = S_ZEND;
          end else if (!j_r) begin
            j_nxt     = 1'b1;
            state_nxt = S_NUM;
          end else begin
            tfound_nxt = 1'b0;
            state_nxt  = S_ZEND;
          end
        end
      end

      // keep the strictly earliest breach
      S_ZEND: begin
        if (hit && (tti < best_t_r)) begin
          best_t_nxt  = tti;
          best_z_nxt  = zi_r;
          best_d2_nxt = d2_r;
          active_nxt  = 1'b1;
        end
        k_nxt = '0;
        if (zi_last) begin
          state_nxt = S_DIST;
        end else begin
          zi_nxt    = zi_r + 2'd1;
          state_nxt = S_H;
        end
      end

      // distance root of the winner, then hand the result over
      S_DIST: begin
        if (k_r == '0) begin
          if (active_r) begin
            cmd.op   = AOP_SQI;
            cmd.wide = {best_d2_r, (P_SH)'(0)};
            k_nxt    = k_r + K_W'(1);
          end else begin
            k_nxt = K_W'(SQ_P + 1);
          end
        end else if (k_r <= K_W'(SQ_P)) begin
          cmd.op = AOP_SQS;
          k_nxt  = k_r + K_W'(1);
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_breach_active_nxt         = active_r;
          out_zone_index_nxt            = best_z_r;
          out_impact_time_ms_nxt        = best_t_r;
          out_predicted_distance_mm_nxt = active_r ? res[16:0] : D_NONE;
          state_nxt                     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      j_r          <= 1'b0;
      zi_r         <= 2'd0;
      out_valid_r  <= 1'b0;
      zone_count_r <= 3'd0;
      for (int i = 0; i < GEOM_REGS; i++) begin
        geom_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      zi_r        <= zi_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_idx == REG_ZONE_COUNT) begin
          zone_count_r <= cfg_wdata[2:0];
        end
        for (int i = 0; i < GEOM_REGS; i++) begin
          if (cfg_idx == (REG_GEOM_BASE + CFG_IDX_W'(i))) begin
            geom_r[i] <= cfg_wdata;
          end
        end
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r[0] <= in_cur_x;
      cur_r[1] <= in_cur_y;
      cur_r[2] <= in_cur_z;
      vel_r[0] <= in_vel_x;
      vel_r[1] <= in_vel_y;
      vel_r[2] <= in_vel_z;
      prd_r[0] <= in_pred_x;
      prd_r[1] <= in_pred_y;
      prd_r[2] <= in_pred_z;
      hz_r     <= (in_horizon_ms > HORIZON_MAX) ? HORIZON_MAX : in_horizon_ms;
    end
    a_r       <= a_nxt;
    slow_r    <= slow_nxt;
    h_r       <= h_nxt;
    c_r       <= c_nxt;
    cneg_r    <= cneg_nxt;
    d2_r      <= d2_nxt;
    inside_r  <= inside_nxt;
    s_r       <= s_nxt;
    tfound_r  <= tfound_nxt;
    t_r       <= t_nxt;
    best_t_r  <= best_t_nxt;
    best_z_r  <= best_z_nxt;
    best_d2_r <= best_d2_nxt;
    active_r  <= active_nxt;
    out_breach_active_r         <= out_breach_active_nxt;
    out_zone_index_r            <= out_zone_index_nxt;
    out_impact_time_ms_r        <= out_impact_time_ms_nxt;
    out_predicted_distance_mm_r <= out_predicted_distance_mm_nxt;
  end

  assign out_valid                 = out_valid_r;
  assign out_breach_active         = out_breach_active_r;
  assign out_zone_index            = out_zone_index_r;
  assign out_impact_time_ms        = out_impact_time_ms_r;
  assign out_predicted_distance_mm = out_predicted_distance_mm_r;

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SPEED))
    else $error("transfer in did not start the speed pass");

  a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_H) |-> ({1'b0, zi_r} < n_eff))
    else $error("zone index beyond active zone count");

  a_no_breach: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_breach_active_r) |->
      (out_impact_time_ms_r == T_NONE && out_predicted_distance_mm_r == D_NONE))
    else $error("inactive result carries a time or distance");

  a_breach_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_breach_active_r) |-> (out_impact_time_ms_r != T_NONE))
    else $error("active result without a usable time");
`endif

endmodule

/* src/rszb_alu.sv */
// Shared multiply-accumulate, square root and divide step unit.
`timescale 1ns / 1ps
module rszb_alu import rszb_pkg::*; (
  input  logic             clk,
  input  alu_cmd_t         cmd,
  output logic [ACC_W-1:0] acc,
  output logic [RES_W-1:0] res
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] aux_r, aux_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [RES_W-1:0] res_r, res_nxt;

  logic [2*OPD_W-1:0] prod;
  logic [ACC_W-1:0]   pz, pshift, base, mac_sum;
  logic [REM_W-1:0]   sq_win, sq_trial, sq_diff;
  logic               sq_ge, dv_ge;

  always_comb begin
    prod = (2*OPD_W)'(cmd.x) * (2*OPD_W)'(cmd.y);
    pz   = ACC_W'(prod);
    case (cmd.sh)
      SH_0:    pshift = pz;
      SH_17:   pshift = pz << OPD_W;
      default: pshift = pz << (2*OPD_W);
    endcase
    base    = cmd.clr ? '0 : acc_r;
    mac_sum = cmd.neg ? (base - pshift) : (base + pshift);

    // bring down the next two operand bits, try (2*root)*2+1
    sq_win   = {rem_r[REM_W-3:0], aux_r[ACC_W-1 -: 2]};
    sq_trial = {(REM_W-RES_W-2)'(0), res_r, 2'b01};
    sq_ge    = sq_win >= sq_trial;
    sq_diff  = sq_win - sq_trial;

    dv_ge = acc_r >= aux_r;

    acc_nxt = acc_r;
    aux_nxt = aux_r;
    rem_nxt = rem_r;
    res_nxt = res_r;
    unique case (cmd.op)
      AOP_NOP: ;
      AOP_MAC: acc_nxt = mac_sum;
      AOP_SQI: begin
        aux_nxt = cmd.wide;
        rem_nxt = '0;
        res_nxt = '0;
      end
      AOP_SQS: begin
        rem_nxt = sq_ge ? sq_diff : sq_win;
        res_nxt = {res_r[RES_W-2:0], sq_ge};
        aux_nxt = aux_r << 2;
      end
      AOP_DVI: begin
        aux_nxt = cmd.wide;
        res_nxt = '0;
      end
      AOP_DVS: begin
        if (dv_ge) begin
          acc_nxt = acc_r - aux_r;
        end
        res_nxt = {res_r[RES_W-2:0], dv_ge};
        aux_nxt = aux_r >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    aux_r <= aux_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign acc = acc_r;
  assign res = res_r;

endmodule

/* tb/sv/tb_ray_sphere_zone_breach_predictor.sv */
// Self-checking testbench for the ray-sphere zone breach predictor.
`timescale 1ns / 1ps
module tb_ray_sphere_zone_breach_predictor import rszb_pkg::*; ();

  typedef struct {
    logic signed [15:0] cx, cy, cz, vx, vy, vz, px, py, pz;
    logic [15:0]        hor;
  } query_t;

  typedef struct {
    logic        active;
    logic [1:0]  zone;
    logic [15:0] tms;
    logic [16:0] dist_mm;
  } breach_t;

  localparam int DRAIN_CYCLES = 500;     // one worst-case query plus margin
  localparam int STALL_LIMIT  = 50000;   // cycles with no transfer at all
  localparam int HOLD_CYCLES  = 3000;    // long receiver hold-off

  logic clk = 0;
  logic rst_n = 0;

  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_cur_x = 0, in_cur_y = 0, in_cur_z = 0;
  logic signed [15:0] in_vel_x = 0, in_vel_y = 0, in_vel_z = 0;
  logic signed [15:0] in_pred_x = 0, in_pred_y = 0, in_pred_z = 0;
  logic [15:0] in_horizon_ms = 0;
  logic out_valid;
  logic out_ready = 0;
  logic out_breach_active;
  logic [1:0] out_zone_index;
  logic [15:0] out_impact_time_ms;
  logic [16:0] out_predicted_distance_mm;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ray_sphere_zone_breach_predictor uut (.*);

  always #4 clk = ~clk;

  // Shadow copy of the configuration registers
  logic [2:0]  zone_count_sh = 0;
  logic [63:0] geom_sh [GEOM_REGS] = '{default: '0};

  query_t  query_q [$];
  breach_t breach_q [$];
  query_t  cur_query;
  int send_idle = 10, recv_idle = 68;
  int errors = 0;
  bit hold_req = 0;

  // Floor square root of a wide unsigned value
  function automatic logic [127:0] isqrt(logic [127:0] d);
    logic [127:0] r, cand;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand <= d) r = cand;
    end
    return r;
  endfunction

  function automatic logic [15:0] entry_ms(longint a, longint h, longint c, longint hor);
    logic signed [127:0] hw, aw, cw, disc;
    longint s, num, t;
    if (c < 0) return 16'd0;
    if (a == 0) return T_NONE;
    hw = h; aw = a; cw = c;
    disc = hw * hw - aw * cw;
    if (disc < 0) return T_NONE;
    s = longint'(isqrt(disc));
    for (int k = 0; k < 2; k++) begin
      num = (k == 0) ? -h - s : -h + s;
      if (num >= 0) begin
        t = (num * 1000) / a;
        if (t <= hor) return t[15:0];
      end
    end
    return T_NONE;
  endfunction

  function automatic breach_t predict_breach(query_t q);
    breach_t res;
    longint a, hor, n, zx, zy, zz, r, ox, oy, oz, h, c, dx, dy, dz, d2;
    logic [15:0] t, tti;
    logic [63:0] g;
    logic [127:0] root;
    bit slow;
    res = '{active: 0, zone: 0, tms: T_NONE, dist_mm: D_NONE};
    a = longint'(q.vx) * q.vx + longint'(q.vy) * q.vy + longint'(q.vz) * q.vz;
    slow = a < 100;
    hor = (q.hor > HORIZON_MAX) ? HORIZON_MAX : q.hor;
    n = zone_count_sh;
    if (n > GEOM_REGS) n = GEOM_REGS;
    for (int z = 0; z < n; z++) begin
      g  = geom_sh[z];
      zx = longint'($signed(g[15:0]));
      zy = longint'($signed(g[31:16]));
      zz = longint'($signed(g[47:32]));
      r  = longint'({48'd0, g[63:48]});
      ox = q.cx - zx; oy = q.cy - zy; oz = q.cz - zz;
      h  = ox * q.vx + oy * q.vy + oz * q.vz;
      c  = ox * ox + oy * oy + oz * oz - r * r;
      dx = q.px - zx; dy = q.py - zy; dz = q.pz - zz;
      d2 = dx * dx + dy * dy + dz * dz;
      t  = entry_ms(a, h, c, hor);
      if (t == T_NONE && d2 >= r * r) continue;
      if (t == T_NONE) tti = 0;
      else if (slow) tti = T_NONE;
      else tti = t;
      if (tti < res.tms) begin
        root          = isqrt(d2);
        res.active    = 1;
        res.zone      = z[1:0];
        res.tms       = tti;
        res.dist_mm   = root[16:0];
      end
    end
    return res;
  endfunction

  // Driver: present the next pending query, predict on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) breach_q.insert(breach_q.size(), predict_breach(cur_query));
      if (!in_valid || in_ready) begin
        if (query_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_query = query_q.pop_front();
          in_cur_x <= cur_query.cx; in_cur_y <= cur_query.cy; in_cur_z <= cur_query.cz;
          in_vel_x <= cur_query.vx; in_vel_y <= cur_query.vy; in_vel_z <= cur_query.vz;
          in_pred_x <= cur_query.px; in_pred_y <= cur_query.py;
          in_pred_z <= cur_query.pz;
          in_horizon_ms <= cur_query.hor;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  int  hold_cnt = 0;
  bit  hold_used = 0;
  always @(posedge clk) begin
    breach_t e;
    if (rst_n && out_valid && out_ready) begin
      if (breach_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = breach_q.pop_front();
        if (out_breach_active !== e.active || out_zone_index !== e.zone ||
            out_impact_time_ms !== e.tms || out_predicted_distance_mm !== e.dist_mm) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp act=%0d zone=%0d t=%0d d=%0d, %s%0d zone=%0d t=%0d d=%0d",
                     e.active, e.zone, e.tms, e.dist_mm, "got act=", out_breach_active,
                     out_zone_index, out_impact_time_ms, out_predicted_distance_mm);
        end
      end
    end
    // Hold off for a long stretch once, so the block backs up its input
    if (hold_req && !hold_used) begin
      hold_used <= 1;
      hold_cnt  <= HOLD_CYCLES;
      out_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic longint srand(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic add_query(query_t q);
    query_q.insert(query_q.size(), q);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == REG_ZONE_COUNT) zone_count_sh = val[2:0];
    else if (idx <= GEOM_REGS) geom_sh[idx - REG_GEOM_BASE] = val;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Wait until every transfer is done and the block has gone quiet
  task automatic drain();
    while (query_q.size() > 0 || in_valid || breach_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pack_zone(longint x, longint y, longint z, longint r);
    return {r[15:0], z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic query_t mk_query(longint cx, cy, cz, vx, vy, vz, px, py, pz, hor);
    query_t q;
    q.cx = cx[15:0]; q.cy = cy[15:0]; q.cz = cz[15:0];
    q.vx = vx[15:0]; q.vy = vy[15:0]; q.vz = vz[15:0];
    q.px = px[15:0]; q.py = py[15:0]; q.pz = pz[15:0];
    q.hor = hor[15:0];
    return q;
  endfunction

  function automatic query_t noise_query();
    query_t q;
    q.cx = 16'($urandom); q.cy = 16'($urandom); q.cz = 16'($urandom);
    q.vx = 16'($urandom); q.vy = 16'($urandom); q.vz = 16'($urandom);
    q.px = 16'($urandom); q.py = 16'($urandom); q.pz = 16'($urandom);
    q.hor = 16'($urandom);
    return q;
  endfunction

  // Query aimed near one zone, moving roughly toward its centre
  function automatic query_t aimed_query();
    query_t q;
    logic [63:0] g;
    longint c[3], o[3], v[3], p[3], r, span, m, hor;
    g = geom_sh[$urandom_range(0, GEOM_REGS - 1)];
    c[0] = longint'($signed(g[15:0]));
    c[1] = longint'($signed(g[31:16]));
    c[2] = longint'($signed(g[47:32]));
    r = g[63:48];
    span = (r * 3 > 30000) ? 30000 : r * 3 + 200;
    m = $urandom_range(1, 24);
    hor = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 65535);
    for (int i = 0; i < 3; i++) begin
      o[i] = sat16(c[i] + srand(int'(span)));
      if ($urandom_range(0, 9) == 0) v[i] = srand(6);
      else v[i] = sat16((c[i] - o[i]) * m / 8 + srand(300));
      if ($urandom_range(0, 1) == 0) p[i] = sat16(o[i] + v[i] * hor / 1000);
      else p[i] = sat16(c[i] + srand(int'(span / 2 + 1)));
    end
    q = mk_query(o[0], o[1], o[2], v[0], v[1], v[2], p[0], p[1], p[2], hor);
    return q;
  endfunction

  function automatic logic [63:0] rand_zone(bit extreme);
    if (extreme) return {$urandom, $urandom};
    return pack_zone(srand(20000), srand(20000), srand(20000), $urandom_range(0, 20000));
  endfunction

  initial begin
    int counts [8];
    counts = '{4, 3, 7, 4, 1, 0, 4, 2};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: fixed zones including the far corners and a zero radius
    write_reg(REG_ZONE_COUNT, 64'd4);
    write_reg(REG_GEOM_BASE + CFG_IDX_W'(0), pack_zone(0, 0, 0, 1000));
    write_reg(REG_GEOM_BASE + CFG_IDX_W'(1), pack_zone(5000, 0, 0, 500));
    write_reg(REG_GEOM_BASE + CFG_IDX_W'(2), pack_zone(-32768, -32768, -32768, 65535));
    write_reg(REG_GEOM_BASE + CFG_IDX_W'(3), pack_zone(32767, 32767, 32767, 0));
    // unknown index, ignored
    write_reg(REG_GEOM_BASE + CFG_IDX_W'(GEOM_REGS), 64'hFFFF_FFFF_FFFF_FFFF);
    end_writes();
    // already inside zone 0
    add_query(mk_query(10, 20, 30, 0, 0, 0, 3000, 3000, 3000, 100));
    // approaching zone 0 head on, both roots positive
    add_query(mk_query(-5000, 0, 0, 2000, 0, 0, -4000, 0, 0, 5000));
    // entry beyond the horizon
    add_query(mk_query(-5000, 0, 0, 2000, 0, 0, -4000, 0, 0, 1000));
    // horizon zero and horizon all ones
    add_query(mk_query(-1000, 0, 0, 100, 0, 0, -1000, 0, 0, 0));
    add_query(mk_query(-30000, 0, 0, 1, 0, 0, 30000, 0, 0, 65535));
    // ray missing zones 0, 1 and 3; the start lies inside the wide zone 2
    add_query(mk_query(0, 9000, 0, 3000, 0, 0, 9000, 9000, 0, 60000));
    // moving away from zone 0
    add_query(mk_query(3000, 0, 0, 1000, 0, 0, 6000, 0, 0, 60000));
    // stationary, predicted point inside zone 1
    add_query(mk_query(9000, 9000, 0, 0, 0, 0, 5100, 0, 0, 1000));
    // slow point whose ray enters zone 1: no usable time
    add_query(mk_query(4000, 0, 0, 9, 0, 0, 9000, 9000, 0, 65534));
    // slow point inside zone 0: no usable time, so no breach
    add_query(mk_query(0, 0, 0, 5, 5, 5, 0, 0, 0, 10));
    // stationary inside zone 0, predicted point inside zone 1: only zone 1 breaches, at time 0
    add_query(mk_query(900, 0, 0, 0, 0, 0, 5100, 0, 0, 10));
    // extremes of every field
    add_query(mk_query(32767, 32767, 32767, 32767, 32767, 32767,
                       32767, 32767, 32767, 65535));
    add_query(mk_query(-32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, -32768, -32768, 0));
    add_query(mk_query(32767, -32768, 32767, -32768, 32767, -32768,
                       -32768, 32767, -32768, 65534));
    add_query(mk_query(-32768, 0, 0, 32767, 0, 0, 0, 0, 0, 65535));
    // grazing zone 1 tangentially
    add_query(mk_query(0, 500, 0, 1000, 0, 0, 9000, 500, 0, 20000));
    drain();

    // Random phases over several configurations
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3)      begin send_idle = 68; recv_idle = 10; end
      else if (ph == 6) begin send_idle = 0;  recv_idle = 0;  end
      write_reg(REG_ZONE_COUNT, 64'(counts[ph]));
      for (int k = 0; k < GEOM_REGS; k++)
        write_reg(REG_GEOM_BASE + CFG_IDX_W'(k),
                  rand_zone(ph == 4 || $urandom_range(0, 9) == 0));
      end_writes();
      for (int i = 0; i < 118; i++) begin
        if (ph == 2 && i == 40) hold_req = 1;
        if ($urandom_range(0, 99) < 75) add_query(aimed_query());
        else add_query(noise_query());
        if (query_q.size() > 8) @(posedge clk);
        while (query_q.size() > 8) @(posedge clk);
      end
      drain();
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* ray_sphere_zone_breach_predictor.f */
src/rszb_pkg.sv
src/rszb_alu.sv
src/ray_sphere_zone_breach_predictor.sv
tb/sv/tb_ray_sphere_zone_breach_predictor.sv
